/* hdl/assert_macros.svh */
// Assertion macros for the RTL, included by float_format_converter_core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, pre, post)
`define ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

/* hdl/ffc_pkg.sv */
// Shared types and constants for the float format converter.
`default_nettype none
package ffc_pkg;
   typedef enum logic [1:0] {
      CMD_F32_TO_F16  = 2'd0,
      CMD_F16_TO_F32  = 2'd1,
      CMD_F32_TO_BF16 = 2'd2,
      CMD_BF16_TO_F32 = 2'd3
   } cmd_type;
   localparam int unsigned FP32_BIAS = 127;
   localparam int unsigned FP16_BIAS = 15;
endpackage
`default_nettype wire

/* hdl/ffc_convert.sv */
// Combinational conversion datapath for all four commands.
`default_nettype none
module ffc_convert (
   input  ffc_pkg::cmd_type command,
   input  logic [31:0]      operand_bits,
   output logic [31:0]      result_bits
);
   import ffc_pkg::*;

   logic        s32, s16;
   logic [7:0]  e32;
   logic [22:0] m32;
   logic [4:0]  e16;
   logic [9:0]  m16;
   logic [15:0] h_res, b_res;
   logic [31:0] f_res;
   logic [8:0]  be;
   logic [10:0] nq;
   logic        nr;
   logic [23:0] sm;
   logic [4:0]  sh;
   logic [23:0] sq, srem, shalf;
   logic [15:0] bq;
   logic        br;
   logic [3:0]  lz;
   logic [9:0]  nm;

   always_comb begin
      s32 = operand_bits[31];
      e32 = operand_bits[30:23];
      m32 = operand_bits[22:0];
      s16 = operand_bits[15];
      e16 = operand_bits[14:10];
      m16 = operand_bits[9:0];
      // fp32 -> fp16; be holds the rebiased exponent in 9-bit two's complement
      be = {1'b0, e32} - 9'(FP32_BIAS - FP16_BIAS);
      nr = m32[12] && ((m32[11:0] != 12'd0) || m32[13]);
      nq = {1'b0, m32[22:13]} + 11'(nr);
      sm = {1'b1, m32};
      sh = 5'(5'd14 - be[4:0]);
      sq = sm >> sh;
      srem = sm & ((24'd1 << sh) - 24'd1);
      shalf = 24'd1 << (sh - 5'd1);
      if ((srem > shalf) || ((srem == shalf) && sq[0])) sq = sq + 24'd1;
      if (e32 == 8'd0) h_res = {s32, 15'd0};
      else if (e32 == 8'hFF)
         h_res = (m32 == 23'd0) ? {s32, 15'h7C00} : {s32, 5'h1F, 1'b1, m32[21:13]};
      else if (!be[8] && be >= 9'd31) h_res = {s32, 15'h7C00};
      else if (!be[8] && be != 9'd0) h_res = {s32, 15'({be[4:0], 10'd0} + 15'(nq))};
      else if (be[8] ? (be >= 9'h1F6) : 1'b1) h_res = {s32, 15'(sq)};
      else h_res = {s32, 15'd0};
      // fp32 -> bf16
      br = operand_bits[15] && ((operand_bits[14:0] != 15'd0) || operand_bits[16]);
      bq = {1'b0, operand_bits[30:16]} + 16'(br);
      if (e32 == 8'hFF)
         b_res = (m32 == 23'd0) ? {s32, 15'h7F80} : {s32, 8'hFF, 1'b1, m32[21:16]};
      else b_res = {s32, bq[14:0]};
      // fp16 -> fp32 subnormal normalize
      lz = 4'd0;
      for (int i = 0; i < 10; i++) if (m16[i]) lz = 4'(9 - i);
      nm = m16 << (lz + 4'd1);
      f_res = 32'd0;
      case (command)
         CMD_F32_TO_F16:  f_res = {16'd0, h_res};
         CMD_F32_TO_BF16: f_res = {16'd0, b_res};
         CMD_F16_TO_F32: begin
            if (e16 == 5'h1F)
               f_res = (m16 == 10'd0) ? {s16, 31'h7F800000}
                                      : {s16, 8'hFF, 1'b1, m16[8:0], 13'd0};
            else if (e16 == 5'd0)
               f_res = (m16 == 10'd0) ? {s16, 31'd0}
                                      : {s16, 8'(8'd112 - {4'd0, lz}), nm, 13'd0};
            else f_res = {s16, 8'({3'd0, e16} + 8'(FP32_BIAS - FP16_BIAS)), m16, 13'd0};
         end
         CMD_BF16_TO_F32: begin
            f_res = {operand_bits[15:0], 16'd0};
            if (operand_bits[14:7] == 8'hFF && operand_bits[6:0] != 7'd0) f_res[22] = 1'b1;
         end
         default: f_res = 32'd0;
      endcase
      result_bits = f_res;
   end
endmodule
`default_nettype wire

/* hdl/float_format_converter_core.sv */
// Top level: input register, conversion logic, output register with skid.
// Path from req accept to rsp valid: input reg, then result reg.
// Throughput: one transaction per cycle while the skid register is empty; the converter is a single pass.
// A skid register holds one result while rsp_tready is low; req_tready drops while it is full.
// Reset (synchronous, active high) empties all stages; no data state.
`default_nettype none
`include "assert_macros.svh"
module float_format_converter_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // [1:0] command, [33:2] operand_bits, rest 0
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata   // [31:0] result_bits
);
   import ffc_pkg::*;

   logic        in_v_ff, out_v_ff, sk_v_ff;
   cmd_type     cmd_ff;
   logic [31:0] op_ff, out_ff, sk_ff, conv;
   logic        adv;

   ffc_convert u_conv (.command(cmd_ff), .operand_bits(op_ff), .result_bits(conv));

   // input stage advances whenever skid is empty
   assign adv = !sk_v_ff;
   assign req_tready = adv;
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
         out_v_ff <= 1'b0;
         sk_v_ff <= 1'b0;
      end else begin
         if (adv) begin
            in_v_ff <= req_tvalid;
            cmd_ff <= cmd_type'(req_tdata[1:0]);
            op_ff <= req_tdata[33:2];
            if (in_v_ff && out_v_ff && !rsp_tready) begin
               sk_v_ff <= 1'b1;
               sk_ff <= conv;
            end else if (!out_v_ff || rsp_tready) begin
               out_v_ff <= in_v_ff;
               out_ff <= conv;
            end
         end else if (rsp_tready) begin
            out_ff <= sk_ff;
            sk_v_ff <= 1'b0;
         end
      end
   end

   `ASSERT_IMPLIES(a_skid_needs_out, clock, reset, sk_v_ff, out_v_ff)
   `ASSERT_NEXT(a_out_hold, clock, reset, out_v_ff && !rsp_tready, out_v_ff && $stable(out_ff))
   `ASSERT_IMPLIES(a_ready_skid, clock, reset, req_tready, !sk_v_ff)
endmodule
`default_nettype wire

/* test/ffc_checker.sv */
// Checker for the float format converter: predicts each conversion and compares results.
`default_nettype none
module ffc_checker
   import ffc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   output int          fail_count,
   output int          pending_count
);
   logic [31:0] expected_q[$];

   // shift right by s with round to nearest, ties to even
   function automatic logic [31:0] round_shift(logic [31:0] v, int s);
      logic [31:0] q, rem, half;
      q = v >> s;
      rem = v & ((32'd1 << s) - 32'd1);
      half = 32'd1 << (s - 1);
      if (rem > half || (rem == half && q[0])) q = q + 32'd1;
      return q;
   endfunction

   function automatic logic [31:0] narrow_to_half(logic [31:0] x);
      logic [15:0] sign;
      logic [7:0] e;
      logic [22:0] m;
      int be;
      sign = {x[31], 15'd0};
      e = x[30:23];
      m = x[22:0];
      if (e == 8'd0) return {16'd0, sign};
      if (e == 8'hFF) begin
         if (m == 0) return {16'd0, sign | 16'h7C00};
         return {16'd0, sign | 16'h7E00 | 16'(m >> 13)};
      end
      be = int'(e) - int'(FP32_BIAS) + int'(FP16_BIAS);
      if (be >= 31) return {16'd0, sign | 16'h7C00};
      if (be >= 1)
         return {16'd0, sign | 16'((32'(be) << 10) + round_shift({9'd0, m}, 13))};
      if (be >= -10)
         return {16'd0, sign | 16'(round_shift({9'd1, m}, 14 - be))};
      return {16'd0, sign};
   endfunction

   function automatic logic [31:0] widen_half(logic [15:0] h);
      logic [31:0] sign;
      logic [4:0] e;
      logic [9:0] m;
      int p;
      sign = {h[15], 31'd0};
      e = h[14:10];
      m = h[9:0];
      if (e == 5'h1F) begin
         if (m == 0) return sign | 32'h7F800000;
         return sign | 32'h7FC00000 | (32'(m) << 13);
      end
      if (e == 0) begin
         if (m == 0) return sign;
         p = 9;
         while (!m[p]) p--;
         return sign | (32'(p + 103) << 23) | ((32'(m) << (23 - p)) & 32'h7FFFFF);
      end
      return sign | ((32'(e) + FP32_BIAS - FP16_BIAS) << 23) | (32'(m) << 13);
   endfunction

   function automatic logic [31:0] narrow_to_brain(logic [31:0] x);
      logic [15:0] sign;
      sign = {x[31], 15'd0};
      if (x[30:23] == 8'hFF) begin
         if (x[22:0] == 0) return {16'd0, sign | 16'h7F80};
         return {16'd0, sign | 16'h7FC0 | 16'(x[22:16])};
      end
      return {16'd0, sign | 16'(round_shift({1'b0, x[30:0]}, 16))};
   endfunction

   function automatic logic [31:0] convert_operand(cmd_type cmd, logic [31:0] op);
      logic [31:0] w;
      case (cmd)
         CMD_F32_TO_F16: return narrow_to_half(op);
         CMD_F16_TO_F32: return widen_half(op[15:0]);
         CMD_F32_TO_BF16: return narrow_to_brain(op);
         default: begin
            w = {op[15:0], 16'd0};
            if (w[30:23] == 8'hFF && w[22:0] != 0) w[22] = 1'b1;
            return w;
         end
      endcase
   endfunction

   assign pending_count = expected_q.size();

   always @(posedge clock) begin
      logic [31:0] exp_bits;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_q.size() == 0) begin
               $error("unexpected transaction result_bits=%h", rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               exp_bits = expected_q.pop_front();
               if (rsp_tdata !== exp_bits) begin
                  $error("result_bits expected %h actual %h", exp_bits, rsp_tdata);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_tvalid && req_tready)
            expected_q.push_back(convert_operand(cmd_type'(req_tdata[1:0]),
                                                 req_tdata[33:2]));
      end
   end
endmodule
`default_nettype wire

/* test/tb_float_format_converter_core.sv */
// Testbench top: stimulus, idling control and verdict for the format converter.
`default_nettype none
module tb_float_format_converter_core;
   import ffc_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [39:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   int fail_count, pending_count;
   int send_idle_pct = 34, recv_idle_pct = 50;
   bit hold_off = 1'b0;
   int quiet_cycles = 0;

   always #4 clock = ~clock;

   float_format_converter_core uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   ffc_checker chk (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   // receiver stalls
   always @(negedge clock)
      rsp_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 5000) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // leaves tvalid high after the accept; a later idle or the phase end drops it
   task automatic send_item(cmd_type cmd, logic [31:0] op);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {6'd0, op, cmd};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // random operand biased toward interesting exponents and rounding bit patterns
   function automatic logic [31:0] pick_operand(cmd_type cmd);
      logic [31:0] v;
      v = $urandom;
      if (cmd == CMD_F32_TO_F16 || cmd == CMD_F32_TO_BF16) begin
         case ($urandom_range(5))
            0: v[30:23] = 8'(102 + $urandom_range(40));
            1: v[30:23] = $urandom_range(1) ? 8'hFF : 8'h00;
            2: v[30:23] = 8'(112 + $urandom_range(32));
            3: v[12:0] = $urandom_range(1) ? 13'h1000 : 13'h0000;
            4: v[15:0] = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
            default: ;
         endcase
      end else if ($urandom_range(3) == 0) begin
         v[14:10] = $urandom_range(1) ? 5'h1F : 5'h00;
         v[14:7] = cmd == CMD_BF16_TO_F32 ? ($urandom_range(1) ? 8'hFF : 8'h00) : v[14:7];
      end
      return v;
   endfunction

   task automatic random_phase(int count);
      cmd_type cmd;
      for (int i = 0; i < count; i++) begin
         cmd = cmd_type'($urandom_range(3));
         send_item(cmd, pick_operand(cmd));
      end
      req_tvalid <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      logic [31:0] directed[$];
      int stall;
      directed = '{32'h00000000, 32'h80000000, 32'h7F800000, 32'hFF800000,
                   32'h7F800001, 32'hFFFFFFFF, 32'h00000001, 32'h477FF000,
                   32'h477FEFFF, 32'h33000000, 32'h33000001, 32'h387FE000,
                   32'h3F801000, 32'h3F803000, 32'h7F7FFFFF, 32'hFFFF7C01,
                   32'h00000200, 32'h0000FC00, 32'h007FFFFF, 32'h12340080};
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (directed[i])
         for (int c = 0; c < 4; c++) send_item(cmd_type'(c), directed[i]);
      random_phase(550);
      // sender pauses until all results are back
      while (pending_count != 0) @(negedge clock);
      send_idle_pct = 50;
      recv_idle_pct = 34;
      random_phase(550);
      // long receiver hold-off with sender pushing
      fork
         begin
            hold_off = 1'b1;
            stall = 0;
            while (stall < 60) begin
               @(negedge clock);
               stall++;
            end
            hold_off = 1'b0;
         end
      join_none
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_phase(520);
      while (pending_count != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule
`default_nettype wire
